@@ hdl/lfu_pkg.sv @@
`default_nettype none
package lfu_pkg;
	localparam int CMD_BITS = 1;
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;
	localparam int CAP_BITS = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
endpackage
`default_nettype wire

@@ hdl/lfu_cache_with_lru_tiebreak.sv @@
// The entry memory has a single port, so each word is handled in passes over it: one pass
// matches the key and picks a victim; when the word hits or stores an entry, the write-back
// and a second pass renewing the ranks follow. A get miss or an ignored put skips both.
// A new word is accepted only when idle, after the previous result has been taken.
// Reset clears valid bits, occupancy, the capacity register (to 16) and the
// controller; the entry memory itself is not cleared.
`default_nettype none
module lfu_cache_with_lru_tiebreak #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [lfu_pkg::CAP_BITS-1:0] cfg_data,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// key, value
	input  wire logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
	// command
	input  wire logic s_tuser,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// read_value
	output logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata,
	// hit, evicted
	output logic [1:0] m_tuser
);
	import lfu_pkg::*;

	localparam int IB = $clog2(CAPACITY);
	localparam int RB = (IB < 1) ? 1 : IB;
	localparam int OB = $clog2(CAPACITY + 1);
	localparam int EW = KEY_BITS + VALUE_BITS + COUNT_BITS + RB;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] val;
		logic [COUNT_BITS-1:0] cnt;
		logic [RB-1:0]         rank;
	} entry_t;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DEC, S_ACT, S_REN, S_OUT} state_t;

	state_t state_q;
	entry_t mem [CAPACITY];
	entry_t rd_q;
	logic [CAPACITY-1:0] valid_q;
	logic [OB-1:0] occ_q;
	logic [CAP_BITS-1:0] cap_q;

	logic cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [IB:0] addr_q;   // read address counter
	logic [IB:0] cidx_q;   // index of data arriving in rd_q
	logic rdv_q;
	logic found_q, hv_q, ev_q, renew_q;
	logic [IB-1:0] slot_q, vic_q;
	logic [COUNT_BITS-1:0] vcnt_q;
	logic [RB-1:0] vrank_q, thr_q;
	logic [1:0] mode_q; // rank pass: 0 touch, 1 evict+insert, 2 insert
	logic [VALUE_BITS-1:0] rv_q;
	logic hit_o_q, ev_o_q;

	logic [IB-1:0] ci;
	logic we;
	logic [IB-1:0] wa;
	entry_t wd;
	entry_t mod;
	logic cvalid;
	logic [OB-1:0] cap_eff;
	logic [IB-1:0] free_idx;
	logic have_free;

	assign ci = cidx_q[IB-1:0];
	assign cvalid = valid_q[ci];
	assign cap_eff = (cap_q > CAPACITY[CAP_BITS-1:0] && CAPACITY < 32) ?
		OB'(CAPACITY) : OB'(cap_q);

	always_comb begin
		free_idx = '0;
		have_free = 1'b0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IB'(i);
				have_free = 1'b1;
			end
		end
	end

	// Rank update of the entry just read back during the rank pass.
	always_comb begin
		mod = rd_q;
		case (mode_q)
			2'd0: if (rd_q.rank < thr_q) mod.rank = rd_q.rank + 1'b1;
			2'd1: if (rd_q.rank < thr_q) mod.rank = rd_q.rank + 1'b1;
			default: mod.rank = rd_q.rank + 1'b1;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {{(((VALUE_BITS+7)/8)*8-VALUE_BITS){1'b0}}, rv_q};
	assign m_tuser = {ev_o_q, hit_o_q};

	// Memory port: read one entry a cycle, write back the entry read.
	always_comb begin
		we = 1'b0;
		wa = ci;
		wd = mod;
		if (state_q == S_REN && rdv_q && cvalid && ci != slot_q) we = 1'b1;
		if (state_q == S_ACT) begin
			we = renew_q;
			wa = slot_q;
			wd = rd_q;
			if (found_q) begin
				wd.val = cmd_q ? val_q : rd_q.val;
				wd.cnt = (rd_q.cnt == CMAX) ? rd_q.cnt : rd_q.cnt + 1'b1;
			end else begin
				wd.key = key_q;
				wd.val = val_q;
				wd.cnt = COUNT_BITS'(1);
			end
			wd.rank = '0;
		end
	end

	// In the decide cycle the scan address is past the end, so the port fetches
	// the matched entry, or else the victim, for the following cycle.
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (state_q == S_DEC) rd_q <= mem[found_q ? slot_q : vic_q];
		else if (addr_q < CAPACITY) rd_q <= mem[addr_q[IB-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			occ_q <= '0;
			cap_q <= CAP_RESET;
			rdv_q <= 1'b0;
			addr_q <= '0;
			cidx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) cap_q <= cfg_data;
					if (s_tvalid) begin
						cmd_q <= s_tuser;
						key_q <= s_tdata[KEY_BITS-1:0];
						val_q <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
						found_q <= 1'b0;
						hv_q <= 1'b0;
						addr_q <= '0;
						rdv_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + 1'b1;
					cidx_q <= addr_q;
					rdv_q <= (addr_q < CAPACITY);
					if (rdv_q && cvalid) begin
						if (rd_q.key == key_q && !found_q) begin
							found_q <= 1'b1;
							slot_q <= ci;
							thr_q <= rd_q.rank;
						end
						if (!hv_q || rd_q.cnt < vcnt_q ||
						    (rd_q.cnt == vcnt_q && rd_q.rank > vrank_q)) begin
							hv_q <= 1'b1;
							vic_q <= ci;
							vcnt_q <= rd_q.cnt;
							vrank_q <= rd_q.rank;
						end
					end
					if (rdv_q && cidx_q == (IB+1)'(CAPACITY - 1)) state_q <= S_DEC;
				end
				S_DEC: begin
					rv_q <= '0;
					ev_o_q <= 1'b0;
					hit_o_q <= found_q;
					renew_q <= 1'b0;
					state_q <= S_OUT;
					if (found_q && (cmd_q == CMD_GET || cap_eff != '0)) begin
						mode_q <= 2'd0;
						renew_q <= 1'b1;
						state_q <= S_ACT;
					end else if (!found_q && cmd_q == CMD_PUT && cap_eff != '0) begin
						if (occ_q >= cap_eff && hv_q) begin
							ev_o_q <= 1'b1;
							slot_q <= vic_q;
							thr_q <= vrank_q;
							mode_q <= 2'd1;
							renew_q <= 1'b1;
							state_q <= S_ACT;
						end else if (have_free) begin
							slot_q <= free_idx;
							mode_q <= 2'd2;
							occ_q <= occ_q + 1'b1;
							renew_q <= 1'b1;
							state_q <= S_ACT;
						end
					end
				end
				S_ACT: begin
					// rd_q holds the entry fetched in the decide cycle, the matched slot on a hit.
					if (found_q && cmd_q == CMD_GET) rv_q <= rd_q.val;
					valid_q[slot_q] <= 1'b1;
					addr_q <= '0;
					rdv_q <= 1'b0;
					state_q <= S_REN;
				end
				S_REN: begin
					addr_q <= addr_q + 1'b1;
					cidx_q <= addr_q;
					rdv_q <= (addr_q < CAPACITY);
					if (rdv_q && cidx_q == (IB+1)'(CAPACITY - 1)) state_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_one_hot_out;
		@(posedge clk) disable iff (!arst_n) m_tvalid |-> !s_tready;
	endproperty
	a_out: assert property (p_one_hot_out) else $error("result and accept overlap");

	property p_occ;
		@(posedge clk) disable iff (!arst_n) occ_q <= OB'(CAPACITY);
	endproperty
	a_occ: assert property (p_occ) else $error("occupancy beyond capacity");

	property p_ev_hit;
		@(posedge clk) disable iff (!arst_n) m_tvalid |-> !(m_tuser[0] && m_tuser[1]);
	endproperty
	a_ev: assert property (p_ev_hit) else $error("eviction on a hit");
endmodule
`default_nettype wire

@@ tb/tb_lfu_cache_with_lru_tiebreak.sv @@
`timescale 1ns / 1ps
module tb_lfu_cache_with_lru_tiebreak;
	import lfu_pkg::*;

	localparam int SLOTS = 16;
	localparam int LATENCY = 2 * SLOTS + 6;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic        command;
		logic [31:0] key;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] read_value;
		logic        evicted;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CAP_BITS-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0] m_tuser;

	lfu_cache_with_lru_tiebreak dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Model state of the store.
	logic        slot_valid [SLOTS];
	logic [31:0] slot_key   [SLOTS];
	logic [31:0] slot_value [SLOTS];
	logic [15:0] slot_count [SLOTS];
	int          slot_rank  [SLOTS];
	int          occupancy;
	int          capacity;

	request_t pending_words[$];
	answer_t  expected_answers[$];
	int       mismatches = 0;
	bit       quiet = 1'b0;
	int       send_gap = 0;
	int       recv_gap = 0;
	bit       hold_start = 1'b0;
	logic     holding = 1'b0;

	function automatic void use_slot(int s);
		int r;
		r = slot_rank[s];
		if (slot_count[s] != COUNT_MAX)
			slot_count[s]++;
		for (int i = 0; i < SLOTS; i++)
			if (slot_valid[i] && slot_rank[i] < r)
				slot_rank[i]++;
		slot_rank[s] = 0;
	endfunction

	function automatic answer_t cache_lookup(request_t w);
		answer_t a;
		int slot, cap, v;
		bit found, have;
		a = '0;
		found = 0;
		slot = 0;
		cap = capacity > SLOTS ? SLOTS : capacity;
		for (int i = 0; i < SLOTS; i++)
			if (!found && slot_valid[i] && slot_key[i] == w.key) begin
				slot = i;
				found = 1;
			end
		a.hit = found;
		if (w.command == CMD_GET) begin
			if (found) begin
				a.read_value = slot_value[slot];
				use_slot(slot);
			end
		end else if (cap != 0) begin
			if (found) begin
				slot_value[slot] = w.value;
				use_slot(slot);
			end else begin
				have = 0;
				if (occupancy >= cap) begin
					v = -1;
					for (int i = 0; i < SLOTS; i++)
						if (slot_valid[i] && (v < 0 || slot_count[i] < slot_count[v] ||
								(slot_count[i] == slot_count[v] && slot_rank[i] > slot_rank[v])))
							v = i;
					if (v >= 0) begin
						slot_valid[v] = 0;
						for (int i = 0; i < SLOTS; i++)
							if (slot_valid[i] && slot_rank[i] > slot_rank[v])
								slot_rank[i]--;
						if (occupancy > 0)
							occupancy--;
						a.evicted = 1;
						slot = v;
						have = 1;
					end
				end
				for (int i = 0; i < SLOTS; i++)
					if (!have && !slot_valid[i]) begin
						slot = i;
						have = 1;
					end
				if (have) begin
					for (int i = 0; i < SLOTS; i++)
						if (slot_valid[i])
							slot_rank[i]++;
					slot_valid[slot] = 1;
					slot_key[slot] = w.key;
					slot_value[slot] = w.value;
					slot_count[slot] = 16'd1;
					slot_rank[slot] = 0;
					occupancy++;
				end
			end
		end
		return a;
	endfunction

	// Driver: the model is advanced as each word is accepted.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_answers.push_back(cache_lookup({s_tuser, s_tdata[31:0], s_tdata[63:32]}));
			void'(pending_words.pop_front());
		end
		if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			s_tvalid <= 1'b0;
		end else if ((s_tvalid && s_tready && pending_words.size() > 0) ||
				(!s_tvalid && pending_words.size() > 0)) begin
			if (!quiet && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(1, 5) - 1;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= {pending_words[0].value, pending_words[0].key};
				s_tuser <= pending_words[0].command;
			end
		end else if (s_tvalid && s_tready) begin
			s_tvalid <= 1'b0;
		end
	end

	// Long receiver hold-off, counted here once it is requested.
	initial begin
		wait (hold_start);
		@(posedge clk);
		holding <= 1'b1;
		repeat (200) @(posedge clk);
		holding <= 1'b0;
	end

	// Monitor.
	always @(posedge clk) begin
		answer_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tuser[0], m_tdata, m_tuser[1]};
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: hit %0b value %h evicted %0b",
						got.hit, got.read_value, got.evicted);
			end else begin
				want = expected_answers.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected hit %0b value %h evicted %0b, got %0b %h %0b",
							want.hit, want.read_value, want.evicted,
							got.hit, got.read_value, got.evicted);
				end
			end
		end
		if (holding) begin
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			recv_gap <= $urandom_range(1, 5) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic queue_word(logic cmd, logic [31:0] k, logic [31:0] v);
		request_t w;
		w.command = cmd;
		w.key = k;
		w.value = v;
		pending_words.push_back(w);
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && !s_tvalid);
		wait (expected_answers.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_capacity(int c);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c[CAP_BITS-1:0];
		do @(posedge clk); while (!cfg_ready);
		capacity = c;
		cfg_valid <= 1'b0;
	endtask

	// Most random traffic reuses a small key pool so hits, ties and evictions occur.
	task automatic random_phase(int n, int pool);
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				k = $urandom;
			else
				k = $urandom_range(0, pool - 1) ^ 32'hA5000000;
			queue_word(1'($urandom_range(0, 1)), k, $urandom);
		end
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_valid[i] = 0;
			slot_key[i] = '0;
			slot_value[i] = '0;
			slot_count[i] = '0;
			slot_rank[i] = 0;
		end
		occupancy = 0;
		capacity = CAP_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, miss, hit, update, fill and LRU tie eviction.
		queue_word(CMD_GET, 32'h0, 32'h0);
		queue_word(CMD_PUT, 32'h0, 32'h80000000);
		queue_word(CMD_PUT, 32'hFFFFFFFF, 32'h7FFFFFFF);
		queue_word(CMD_GET, 32'hFFFFFFFF, 32'h12345678);
		queue_word(CMD_PUT, 32'h0, 32'hFFFFFFFF);
		queue_word(CMD_GET, 32'h0, 32'h0);
		for (int i = 1; i <= 15; i++)
			queue_word(CMD_PUT, 32'h100 + i, i);
		queue_word(CMD_PUT, 32'hDEADBEEF, 32'h5555AAAA);
		queue_word(CMD_GET, 32'h101, 32'h0);
		drain();

		// Capacity zero: puts ignored, gets still hit.
		set_capacity(0);
		queue_word(CMD_PUT, 32'hCAFE0000, 32'h1);
		queue_word(CMD_PUT, 32'hFFFFFFFF, 32'h2);
		queue_word(CMD_GET, 32'hFFFFFFFF, 32'h0);
		drain();

		// Capacity lowered below occupancy, then above the store size.
		set_capacity(3);
		random_phase(150, 8);
		drain();
		set_capacity(31);
		random_phase(150, 24);
		drain();

		// Long receiver hold-off so the block backs up.
		hold_start = 1'b1;
		set_capacity(1);
		random_phase(100, 4);
		drain();

		set_capacity(16);
		random_phase(100, 20);
		// Hammer one key so its count climbs well above the rest.
		for (int i = 0; i < 40; i++)
			queue_word(CMD_GET, 32'hA5000000, 32'h0);
		drain();
		quiet = 1'b1;
		set_capacity(7);
		random_phase(100, 12);
		drain();

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
